// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the group reverse stream RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define GRS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define GRS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/grs_pkg.sv =====
// Shared constants and types for the group reverse stream block.
// No dependencies; imported by grs_ctrl, grs_ostage, the top level and the testbench.
package grs_pkg;

  localparam int MAX_GROUP = 16;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(MAX_GROUP);
  localparam int CNT_W     = $clog2(MAX_GROUP + 1);
  localparam int GS_W      = 5;

  localparam logic [GS_W-1:0] GS_RESET = GS_W'(1);

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
  } wr_req_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } rd_req_t;

endpackage

// ===== rtl/grs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module grs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/grs_ctrl.sv =====
// Sequencer: group size register, held count, buffer write and drain address walk.
// Depends on grs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module grs_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [grs_pkg::GS_W-1:0]   cfg_group_size,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_is_last_in,
  input  logic                       slot_free,
  output grs_pkg::wr_req_t           wr_req,
  output grs_pkg::rd_req_t           rd_req
);

  import grs_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic              state_r, state_nxt;
  logic [GS_W-1:0]   gs_r, gs_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              rev_r, rev_nxt;
  logic              last_r, last_nxt;

  logic              in_fire;
  logic              issue;
  logic              has_room;
  logic [CNT_W-1:0]  n_held;
  logic [CNT_W-1:0]  eff_size;
  logic              full_grp;
  logic              flush;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign issue     = (state_r == ST_DRAIN) && slot_free;

  assign has_room = (held_r < CNT_W'(MAX_GROUP));
  assign n_held   = has_room ? held_r + CNT_W'(1) : held_r;

  // zero acts as one, anything past the buffer depth saturates
  always_comb begin
    if (gs_r == '0) begin
      eff_size = CNT_W'(1);
    end else if (CNT_W'(gs_r) > CNT_W'(MAX_GROUP)) begin
      eff_size = CNT_W'(MAX_GROUP);
    end else begin
      eff_size = CNT_W'(gs_r);
    end
  end

  assign full_grp = (n_held >= eff_size);
  assign flush    = full_grp || in_is_last_in;

  assign wr_req.we   = in_fire && has_room;
  assign wr_req.addr = held_r[ADDR_W-1:0];

  assign rd_req.re   = issue;
  assign rd_req.addr = addr_r;
  assign rd_req.last = last_r && (cnt_r == CNT_W'(1));

  always_comb begin
    gs_nxt    = gs_r;
    state_nxt = state_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    rev_nxt   = rev_r;
    last_nxt  = last_r;
    if (cfg_valid) begin
      gs_nxt = cfg_group_size;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (flush) begin
            state_nxt = ST_DRAIN;
            held_nxt  = '0;
            cnt_nxt   = n_held;
            rev_nxt   = full_grp;
            last_nxt  = in_is_last_in;
            // reverse walk starts at the newest entry
            addr_nxt  = full_grp ? ADDR_W'(n_held - CNT_W'(1)) : '0;
          end else begin
            held_nxt = n_held;
          end
        end
      end
      ST_DRAIN: begin
        if (issue) begin
          cnt_nxt  = cnt_r - CNT_W'(1);
          addr_nxt = rev_r ? addr_r - ADDR_W'(1) : addr_r + ADDR_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      gs_r    <= GS_RESET;
      held_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      gs_r    <= gs_nxt;
      held_r  <= held_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    rev_r  <= rev_nxt;
    last_r <= last_nxt;
  end

  `GRS_ASSERT_IMP(a_drain_cnt, clk, rst_n, state_r == ST_DRAIN, cnt_r != '0)
  `GRS_ASSERT_NXT(a_flush_drain, clk, rst_n, in_fire && flush, state_r == ST_DRAIN)
  `GRS_ASSERT_NXT(a_final_idle, clk, rst_n, issue && (cnt_r == CNT_W'(1)), state_r == ST_IDLE)
  `GRS_ASSERT_IMP(a_held_room, clk, rst_n, state_r == ST_IDLE, held_r < CNT_W'(MAX_GROUP))

endmodule

// ===== rtl/grs_ostage.sv =====
// Output stage: tracks the RAM read register and the result register beat by beat.
// Depends on grs_pkg.
module grs_ostage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  grs_pkg::rd_req_t           rd_req,
  input  logic [grs_pkg::DATA_W-1:0] ram_rdata,
  output logic                       slot_free,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [grs_pkg::DATA_W-1:0] out_value,
  output logic                       out_is_last_out
);

  import grs_pkg::*;

  logic              rd_valid_r, rd_valid_nxt;
  logic              rd_last_r;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r;
  logic              out_last_r;
  logic              xfer;

  // RAM read register holds its word until moved into the result register
  assign xfer      = rd_valid_r && (!out_valid_r || out_ready);
  assign slot_free = !rd_valid_r || xfer;

  always_comb begin
    rd_valid_nxt = rd_valid_r;
    if (rd_req.re) begin
      rd_valid_nxt = 1'b1;
    end else if (xfer) begin
      rd_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.re) begin
      rd_last_r <= rd_req.last;
    end
    if (xfer) begin
      out_value_r <= ram_rdata;
      out_last_r  <= rd_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_is_last_out = out_last_r;

endmodule

// ===== rtl/group_reverse_stream_core.sv =====
// Top level of the group reverse stream block: sequencer, group buffer RAM, output stage.
// Depends on grs_pkg, grs_ram, grs_ctrl and grs_ostage.
//
//   channel | ports                                    | direction
//   --------+------------------------------------------+----------
//   cfg     | cfg_valid cfg_ready cfg_group_size       | write in
//   in      | in_valid in_ready in_value in_is_last_in | beat in
//   out     | out_valid out_ready out_value out_is_last_out | beat out
//
// A beat that leaves its group open is accepted and in_ready stays high.
// A beat that closes a group of n values stops input while the buffer RAM is read,
// one entry per cycle through its single read port while the output stage has room.
// Results leave at one per cycle unless out_ready is low; stalls back up into the drain.
// Synchronous active-low reset; group size resets to 1, buffer contents are not cleared.
module group_reverse_stream_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [grs_pkg::GS_W-1:0]          cfg_group_size,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [grs_pkg::DATA_W-1:0] in_value,
  input  logic                              in_is_last_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [grs_pkg::DATA_W-1:0] out_value,
  output logic                              out_is_last_out
);

  import grs_pkg::*;

  wr_req_t           wr_req;
  rd_req_t           rd_req;
  logic              slot_free;
  logic [DATA_W-1:0] ram_rdata;

  grs_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_group_size (cfg_group_size),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_is_last_in  (in_is_last_in),
    .slot_free      (slot_free),
    .wr_req         (wr_req),
    .rd_req         (rd_req)
  );

  grs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_GROUP)
  ) u_buf (
    .clk   (clk),
    .we    (wr_req.we),
    .waddr (wr_req.addr),
    .wdata (in_value),
    .re    (rd_req.re),
    .raddr (rd_req.addr),
    .rdata (ram_rdata)
  );

  grs_ostage u_ostage (
    .clk             (clk),
    .rst_n           (rst_n),
    .rd_req          (rd_req),
    .ram_rdata       (ram_rdata),
    .slot_free       (slot_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_is_last_out (out_is_last_out)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for group_reverse_stream_core: groups of values come back reversed,
// list tails in order; a scoreboard class predicts the beats. Depends on grs_pkg.
module tb_top;
  import grs_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int SETTLE       = 40;
  localparam int RANDOM_ITEMS = 410;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } elem_t;

  class reverse_scoreboard;
    logic signed [DATA_W-1:0] held [MAX_GROUP];
    int                       held_n;
    logic [GS_W-1:0]          size_reg;
    elem_t                    expected_q [$];
    int                       errors;

    function new();
      held_n   = 0;
      size_reg = GS_RESET;
      errors   = 0;
    endfunction

    function int group_len();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_GROUP) return MAX_GROUP;
      return int'(size_reg);
    endfunction

    function void set_size(logic [GS_W-1:0] s);
      size_reg = s;
    endfunction

    function void note_input(logic signed [DATA_W-1:0] v, logic last);
      elem_t e;
      int    n;
      if (held_n < MAX_GROUP) begin
        held[held_n] = v;
        held_n++;
      end
      n = held_n;
      if (n >= group_len()) begin
        // full group (or size lowered under the held count): all of it reversed
        for (int i = 0; i < n; i++) begin
          e.value = held[n-1-i];
          e.last  = last && (i == n - 1);
          expected_q.push_back(e);
        end
        held_n = 0;
      end else if (last) begin
        for (int i = 0; i < n; i++) begin
          e.value = held[i];
          e.last  = (i == n - 1);
          expected_q.push_back(e);
        end
        held_n = 0;
      end
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] v, logic last);
      elem_t e;
      if (expected_q.size() == 0) begin
        flag_error($sformatf("unexpected beat value=%0d last=%0b", v, last));
        return;
      end
      e = expected_q.pop_front();
      if (e.value !== v || e.last !== last)
        flag_error($sformatf("mismatch: expected value=%0d last=%0b, got value=%0d last=%0b",
                             e.value, e.last, v, last));
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [GS_W-1:0]          cfg_group_size;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_value;
  logic                     in_is_last_in;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_is_last_out;

  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;
  logic cfg_fire = 1'b0;
  int   idle_cycles = 0;
  int   out_wait = 0;
  bit   no_idle = 1'b0;
  int   items_sent = 0;

  reverse_scoreboard sb = new();

  group_reverse_stream_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_group_size (cfg_group_size),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_is_last_in  (in_is_last_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_is_last_out(out_is_last_out)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // handshake monitor and watchdog
  always @(posedge clk) begin
    in_fire  <= rst_n && in_valid && in_ready;
    out_fire <= rst_n && out_valid && out_ready;
    cfg_fire <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_size(cfg_group_size);
      if (in_valid && in_ready) sb.note_input(in_value, in_is_last_in);
      if (out_valid && out_ready) sb.check_result(out_value, out_is_last_out);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("tb_top NOT OK");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // result side back-pressure: a fresh stall length after every accepted beat
  always @(negedge clk) begin
    if (out_fire) out_wait = no_idle ? 0 : $urandom_range(0, 5);
    if (out_wait > 0) begin
      out_ready <= 1'b0;
      out_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic int eff_size(logic [GS_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_GROUP) return MAX_GROUP;
    return int'(s);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(input logic signed [DATA_W-1:0] v, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_value      <= v;
    in_is_last_in <= last;
    do @(negedge clk); while (!in_fire);
    items_sent++;
  endtask

  // wait until every predicted beat is out, then let any drain finish
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_size(input logic [GS_W-1:0] s);
    cfg_valid      <= 1'b1;
    cfg_group_size <= s;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [GS_W-1:0] gs;
    int              eff;
    int              len;
    bit              messy;
    logic            last;

    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_group_size = '0;
    in_valid       = 1'b0;
    in_value       = '0;
    in_is_last_in  = 1'b0;
    out_ready      = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // size 1 out of reset: straight pass-through
    send_beat(32'h7fff_ffff, 1'b0);
    send_beat(32'h8000_0000, 1'b1);
    settle();
    // one full group that also carries the last mark, then a short tail
    write_size(5'd4);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'hffff_ffff, 1'b0);
    send_beat(32'h0000_0001, 1'b0);
    send_beat(32'h0000_0002, 1'b1);
    send_beat(32'h1234_5678, 1'b0);
    send_beat(32'h8765_4321, 1'b1);
    settle();
    // zero behaves as one
    write_size(5'd0);
    send_beat(32'h5555_5555, 1'b0);
    send_beat(32'haaaa_aaaa, 1'b1);
    settle();
    // size lowered while three values are held
    write_size(5'd6);
    send_beat(32'h0000_0011, 1'b0);
    send_beat(32'h0000_0022, 1'b0);
    send_beat(32'h0000_0033, 1'b0);
    settle();
    write_size(5'd2);
    send_beat(32'h0000_0044, 1'b1);
    settle();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       gs = 5'd0;
        1:       gs = 5'd31;
        2:       gs = 5'd17;
        3:       gs = 5'd16;
        4:       gs = 5'd1;
        default: gs = GS_W'($urandom_range(2, 8));
      endcase
      eff = eff_size(gs);
      settle();
      write_size(gs);
      no_idle = ($urandom_range(0, 3) == 0);
      messy   = ($urandom_range(0, 7) == 0);
      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(1, 2 * eff + 2);
        for (int k = 0; k < len; k++) begin
          last = messy ? ($urandom_range(0, 3) == 0) : (k == len - 1);
          send_beat(pick_value(), last);
        end
      end
      // sometimes leave a list open across the next size change
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(0, eff - 1)) send_beat(pick_value(), 1'b0);
    end

    settle();
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
